### src/box_filter_window_sum_top_assert.svh
// Assertion macros shared by the box filter checker.
// Each macro expands to one labeled concurrent assertion.
`ifndef BOX_FILTER_WINDOW_SUM_TOP_ASSERT_SVH
`define BOX_FILTER_WINDOW_SUM_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define BFWS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define BFWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold on every edge that follows a reset edge.
`define BFWS_ASSERT_AFTER_RESET(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) $past(rst) |-> (cond)) \
      else $error(msg);

`endif

### src/bfws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfws_pkg
// Shared types and constants of the box filter window sum block: payload
// structs, configuration register codes and default sizes.
// ----------------------------------------------------------------------------
package bfws_pkg;

   // default sizes, used as top-level parameter defaults
   localparam int MAX_ROWS_DEFAULT        = 1024;
   localparam int MAX_COLS_DEFAULT        = 4096;
   localparam int MAX_HALF_KERNEL_DEFAULT = 15;
   localparam int PIXEL_BITS_DEFAULT      = 16;

   // field widths
   localparam int PIXEL_FIELD_W = 16;
   localparam int CENTRE_ROW_W  = 10;
   localparam int CENTRE_COL_W  = 12;
   localparam int COL_SUM_BITS  = 21;
   localparam int WIN_SUM_BITS  = 26;

   // configuration registers
   localparam int IMAGE_ROWS_W  = 11;
   localparam int IMAGE_COLS_W  = 13;
   localparam int HALF_KERNEL_W = 4;
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 16;

   localparam logic [IMAGE_ROWS_W-1:0]  IMAGE_ROWS_RESET  = IMAGE_ROWS_W'(1024);
   localparam logic [IMAGE_COLS_W-1:0]  IMAGE_COLS_RESET  = IMAGE_COLS_W'(1024);
   localparam logic [HALF_KERNEL_W-1:0] HALF_KERNEL_RESET = HALF_KERNEL_W'(1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_ROWS       = 4'd0,
      CSR_IMAGE_COLS       = 4'd1,
      CSR_HALF_KERNEL_ROWS = 4'd2,
      CSR_HALF_KERNEL_COLS = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic [PIXEL_FIELD_W-1:0] pixel;
      logic                     frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [WIN_SUM_BITS-1:0] window_sum;
      logic [CENTRE_ROW_W-1:0] centre_row;
      logic [CENTRE_COL_W-1:0] centre_col;
      logic                    frame_done;
   } rsp_payload_type;

endpackage

### src/box_filter_window_sum_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_window_sum_top
// Streaming box filter: exact sum over an odd-sized window for every pixel
// whose window lies inside the frame, built from running sums.
// ----------------------------------------------------------------------------
// Pixels stream in with the row (fast) index first, one beat per clock, and
// the block takes a new beat on every clock that rsp_stall allows. A result
// beat leaves for each pixel whose whole window is inside the frame. It passes
// from the accept edge through the column-sum stage and the window-sum stage
// into the output register; border pixels give no beat. The rate is set by
// the column store and the line store, each read once and written once per
// clock. The user must write configuration through the csr_ port only while
// the block is idle; the block itself does not enforce this. There is no
// clearing pass after reset.
// Sizes beyond MAX_ROWS / MAX_COLS saturate, zero sizes act as one, and half
// kernel sizes saturate at MAX_HALF_KERNEL. frame_start on a beat forces that
// pixel to position (0, 0).
// ----------------------------------------------------------------------------
module box_filter_window_sum_top #(
   parameter int MAX_ROWS        = bfws_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS        = bfws_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_HALF_KERNEL = bfws_pkg::MAX_HALF_KERNEL_DEFAULT,
   parameter int PIXEL_BITS      = bfws_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // pixel beats
   input  logic                             req_valid,
   output logic                             req_stall,
   input  bfws_pkg::req_payload_type        req_payload,
   // result beats
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output bfws_pkg::rsp_payload_type        rsp_payload,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bfws_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bfws_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bfws_pkg::*;

   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int COLS_W  = $clog2(MAX_COLS + 1);
   localparam int HK_W    = $clog2(MAX_HALF_KERNEL + 1);
   localparam int SPAN_W  = HK_W + 1;
   localparam int SLOTS   = 2 * MAX_HALF_KERNEL + 2;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int PIX_W   = (PIXEL_BITS < PIXEL_FIELD_W) ? PIXEL_BITS : PIXEL_FIELD_W;

   // Horizontal-pass info carried from the accept edge to the window stage.
   typedef struct packed {
      logic                    r_zero;   // first pixel of a line
      logic                    r_sub;    // oldest column sum drops out
      logic [SLOT_W-1:0]       rd_slot;  // slot of the column sum that drops out
      logic [SLOT_W-1:0]       wr_slot;  // slot of this column sum
      logic                    emit;     // window complete and inside frame
      logic                    done;     // last pixel of the frame
      logic [CENTRE_ROW_W-1:0] crow;
      logic [CENTRE_COL_W-1:0] ccol;
   } hz_type;

   typedef struct packed {
      logic [ROW_W-1:0]  r;
      logic [SLOT_W-1:0] cslot;
      logic [PIX_W-1:0]  pix;
      logic              c_zero;   // first line of the frame
      logic              c_sub;    // oldest line drops out
      hz_type            hz;
   } s1_type;

   typedef struct packed {
      logic [COL_SUM_BITS-1:0] colsum;
      hz_type                  hz;
   } s2_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [IMAGE_ROWS_W-1:0]  image_rows_ff;
   logic [IMAGE_COLS_W-1:0]  image_cols_ff;
   logic [HALF_KERNEL_W-1:0] hk_rows_ff;
   logic [HALF_KERNEL_W-1:0] hk_cols_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_rows_ff <= IMAGE_ROWS_RESET;
         image_cols_ff <= IMAGE_COLS_RESET;
         hk_rows_ff    <= HALF_KERNEL_RESET;
         hk_cols_ff    <= HALF_KERNEL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_ROWS:       image_rows_ff <= csr_data[IMAGE_ROWS_W-1:0];
            CSR_IMAGE_COLS:       image_cols_ff <= csr_data[IMAGE_COLS_W-1:0];
            CSR_HALF_KERNEL_ROWS: hk_rows_ff    <= csr_data[HALF_KERNEL_W-1:0];
            CSR_HALF_KERNEL_COLS: hk_cols_ff    <= csr_data[HALF_KERNEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective sizes after clamping.
   logic [ROWS_W-1:0] rows_use;
   logic [COLS_W-1:0] cols_use;
   logic [HK_W-1:0]   hr;
   logic [HK_W-1:0]   hc;

   always_comb begin
      if (image_rows_ff == '0) begin
         rows_use = ROWS_W'(1);
      end else if (32'(image_rows_ff) > 32'(MAX_ROWS)) begin
         rows_use = ROWS_W'(MAX_ROWS);
      end else begin
         rows_use = ROWS_W'(image_rows_ff);
      end
      if (image_cols_ff == '0) begin
         cols_use = COLS_W'(1);
      end else if (32'(image_cols_ff) > 32'(MAX_COLS)) begin
         cols_use = COLS_W'(MAX_COLS);
      end else begin
         cols_use = COLS_W'(image_cols_ff);
      end
      hr = (32'(hk_rows_ff) > 32'(MAX_HALF_KERNEL)) ? HK_W'(MAX_HALF_KERNEL)
                                                    : HK_W'(hk_rows_ff);
      hc = (32'(hk_cols_ff) > 32'(MAX_HALF_KERNEL)) ? HK_W'(MAX_HALF_KERNEL)
                                                    : HK_W'(hk_cols_ff);
   end

   // window spans: 2h and 2h+1
   logic [SPAN_W-1:0] span_r;
   logic [SPAN_W-1:0] span_r1;
   logic [SPAN_W-1:0] span_c;
   logic [SPAN_W-1:0] span_c1;

   assign span_r  = {hr, 1'b0};
   assign span_r1 = {hr, 1'b1};
   assign span_c  = {hc, 1'b0};
   assign span_c1 = {hc, 1'b1};

   // ---------------------------------------------------------------------
   // Pipeline handshake. Each stage moves when the one after it frees up;
   // a pixel without a result leaves the window stage without touching the
   // output register.
   // ---------------------------------------------------------------------
   logic   s1_valid_ff;
   s1_type s1_ff;
   logic   s2_valid_ff;
   s2_type s2_ff;
   logic   rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   logic out_adv;
   logic s2_retire;
   logic s2_free;
   logic s1_adv;
   logic s1_free;
   logic accept;

   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign s2_retire = s2_valid_ff && (!s2_ff.hz.emit || out_adv);
   assign s2_free   = !s2_valid_ff || s2_retire;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Accept stage: position of the incoming pixel and everything that only
   // depends on position and configuration.
   // ---------------------------------------------------------------------
   logic [ROW_W-1:0]  row_pos_ff;
   logic [COL_W-1:0]  col_pos_ff;
   logic [SLOT_W-1:0] row_slot_ff;   // row_pos mod SLOTS
   logic [SLOT_W-1:0] col_slot_ff;   // col_pos mod SLOTS

   logic [ROW_W-1:0]  r0;
   logic [COL_W-1:0]  c0;
   logic [SLOT_W-1:0] rslot0;
   logic [SLOT_W-1:0] cslot0;
   logic [SLOT_W-1:0] ls_rd_slot0;
   logic [SLOT_W-1:0] rc_rd_slot0;
   logic [SLOT_W-1:0] rslot_inc;
   logic [SLOT_W-1:0] cslot_inc;
   logic              row_last;
   logic              col_last;
   s1_type            s1_in;

   logic [ROW_W-1:0]  row_pos_in;
   logic [COL_W-1:0]  col_pos_in;
   logic [SLOT_W-1:0] row_slot_in;
   logic [SLOT_W-1:0] col_slot_in;

   always_comb begin
      int ls_diff;
      int rc_diff;
      r0     = req_payload.frame_start ? '0 : row_pos_ff;
      c0     = req_payload.frame_start ? '0 : col_pos_ff;
      rslot0 = req_payload.frame_start ? '0 : row_slot_ff;
      cslot0 = req_payload.frame_start ? '0 : col_slot_ff;

      // slot of the line / column sum leaving the window, modulo SLOTS
      ls_diff = int'(cslot0) - int'(span_c1);
      rc_diff = int'(rslot0) - int'(span_r1);
      ls_rd_slot0 = (ls_diff < 0) ? SLOT_W'(ls_diff + SLOTS) : SLOT_W'(ls_diff);
      rc_rd_slot0 = (rc_diff < 0) ? SLOT_W'(rc_diff + SLOTS) : SLOT_W'(rc_diff);

      rslot_inc = (rslot0 == SLOT_W'(SLOTS - 1)) ? '0 : rslot0 + 1'b1;
      cslot_inc = (cslot0 == SLOT_W'(SLOTS - 1)) ? '0 : cslot0 + 1'b1;
      row_last  = (32'(r0) + 32'd1) >= 32'(rows_use);
      col_last  = (32'(c0) + 32'd1) >= 32'(cols_use);

      s1_in.r         = r0;
      s1_in.cslot     = cslot0;
      s1_in.pix       = req_payload.pixel[PIX_W-1:0];
      s1_in.c_zero    = (c0 == '0);
      s1_in.c_sub     = 32'(c0) >= 32'(span_c1);
      s1_in.hz.r_zero = (r0 == '0);
      s1_in.hz.r_sub  = 32'(r0) >= 32'(span_r1);
      s1_in.hz.rd_slot = rc_rd_slot0;
      s1_in.hz.wr_slot = rslot0;
      s1_in.hz.emit   = (32'(r0) >= 32'(span_r)) && (32'(c0) >= 32'(span_c)) &&
                        (32'(r0) < 32'(rows_use)) && (32'(c0) < 32'(cols_use));
      s1_in.hz.done   = ((32'(r0) + 32'd1) == 32'(rows_use)) &&
                        ((32'(c0) + 32'd1) == 32'(cols_use));
      s1_in.hz.crow   = CENTRE_ROW_W'(32'(r0) - 32'(hr));
      s1_in.hz.ccol   = CENTRE_COL_W'(32'(c0) - 32'(hc));

      // next position: row wraps into the next line, last line wraps the frame
      if (row_last) begin
         row_pos_in  = '0;
         row_slot_in = '0;
         col_pos_in  = col_last ? '0 : c0 + 1'b1;
         col_slot_in = col_last ? '0 : cslot_inc;
      end else begin
         row_pos_in  = r0 + 1'b1;
         row_slot_in = rslot_inc;
         col_pos_in  = c0;
         col_slot_in = cslot0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff  <= '0;
         col_pos_ff  <= '0;
         row_slot_ff <= '0;
         col_slot_ff <= '0;
      end else if (accept) begin
         row_pos_ff  <= row_pos_in;
         col_pos_ff  <= col_pos_in;
         row_slot_ff <= row_slot_in;
         col_slot_ff <= col_slot_in;
      end
   end

   // ---------------------------------------------------------------------
   // Column stage: vertical running sum per fast index. Both stores are
   // read on the accept edge and written when the column stage moves on.
   // A write and a read of the same entry on one edge are bypassed.
   // ---------------------------------------------------------------------
   logic [COL_SUM_BITS-1:0] cws_mem [MAX_ROWS];
   logic [PIX_W-1:0]        ls_mem  [SLOTS][MAX_ROWS];

   logic [COL_SUM_BITS-1:0] cws_rd_ff;
   logic [PIX_W-1:0]        ls_rd_ff;
   logic                    byp_cws_ff;
   logic [COL_SUM_BITS-1:0] byp_cws_data_ff;
   logic                    byp_ls_ff;
   logic [PIX_W-1:0]        byp_ls_data_ff;

   logic [COL_SUM_BITS-1:0] cws_val;
   logic [PIX_W-1:0]        ls_val;
   logic [COL_SUM_BITS-1:0] colsum_in;

   assign cws_val = byp_cws_ff ? byp_cws_data_ff : cws_rd_ff;
   assign ls_val  = byp_ls_ff ? byp_ls_data_ff : ls_rd_ff;

   always_comb begin
      if (s1_ff.c_zero) begin
         colsum_in = COL_SUM_BITS'(s1_ff.pix);
      end else begin
         colsum_in = cws_val + COL_SUM_BITS'(s1_ff.pix)
                   - (s1_ff.c_sub ? COL_SUM_BITS'(ls_val) : COL_SUM_BITS'(0));
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         cws_mem[s1_ff.r]             <= colsum_in;
         ls_mem[s1_ff.cslot][s1_ff.r] <= s1_ff.pix;
      end
      if (accept) begin
         cws_rd_ff <= cws_mem[r0];
         ls_rd_ff  <= ls_mem[ls_rd_slot0][r0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byp_cws_ff      <= s1_adv && (s1_ff.r == r0);
         byp_cws_data_ff <= colsum_in;
         byp_ls_ff       <= s1_adv && (s1_ff.r == r0) && (s1_ff.cslot == ls_rd_slot0);
         byp_ls_data_ff  <= s1_ff.pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------------------
   // Window stage: horizontal running sum over the last 2*hr+1 column sums.
   // ---------------------------------------------------------------------
   logic [WIN_SUM_BITS-1:0] running_ff;
   logic [COL_SUM_BITS-1:0] recent_ff [SLOTS];
   logic [COL_SUM_BITS-1:0] rc_val;
   logic [WIN_SUM_BITS-1:0] running_in;

   assign rc_val = s2_ff.hz.r_sub ? recent_ff[s2_ff.hz.rd_slot] : COL_SUM_BITS'(0);

   always_comb begin
      if (s2_ff.hz.r_zero) begin
         running_in = WIN_SUM_BITS'(s2_ff.colsum);
      end else begin
         running_in = running_ff + WIN_SUM_BITS'(s2_ff.colsum) - WIN_SUM_BITS'(rc_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_ff.colsum <= colsum_in;
         s2_ff.hz     <= s1_ff.hz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
      end else if (s2_retire) begin
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_retire) begin
         recent_ff[s2_ff.hz.wr_slot] <= s2_ff.colsum;
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_retire && s2_ff.hz.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_retire && s2_ff.hz.emit) begin
         rsp_payload_ff.window_sum <= running_in;
         rsp_payload_ff.centre_row <= s2_ff.hz.crow;
         rsp_payload_ff.centre_col <= s2_ff.hz.ccol;
         rsp_payload_ff.frame_done <= s2_ff.hz.done;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### src/bfws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfws_checker
// Port-level assertions for the box filter window sum block, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "box_filter_window_sum_top_assert.svh"

module bfws_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input bfws_pkg::rsp_payload_type rsp_payload
);
   import bfws_pkg::*;

   // no result survives a reset
   `BFWS_ASSERT_AFTER_RESET(a_rsp_clear, clock, reset, !rsp_valid, "result valid after reset")

   // with the output register empty the pipeline always drains, so input flows
   `BFWS_ASSERT_IMPL(a_req_flow, clock, reset, req_valid && !rsp_valid, !req_stall, "input stalled with output empty")

   // a stalled result beat stays and holds its payload
   `BFWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")

endmodule

bind box_filter_window_sum_top bfws_checker u_bfws_checker (.*);

### test/box_filter_window_sum_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_window_sum_top_test
// Self-checking bench for the streaming box filter. A behavioral copy of the
// running-sum filter predicts every window sum from the accepted pixel beats.
// A checker compares each result beat, field by field, with the oldest
// prediction. Directed frames come first, then saturating sizes, a long
// receiver hold-off, and randomized frames with random idling on both sides.
// ----------------------------------------------------------------------------
module box_filter_window_sum_top_test;
   import bfws_pkg::*;

   localparam int MAX_ROWS        = MAX_ROWS_DEFAULT;
   localparam int MAX_COLS        = MAX_COLS_DEFAULT;
   localparam int MAX_HALF_KERNEL = MAX_HALF_KERNEL_DEFAULT;
   localparam int SLOTS           = 2 * MAX_HALF_KERNEL + 2;

   // settling margin for the pipeline before touching registers
   localparam int PIPE_SETTLE     = 8;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_ITEMS    = 1950;
   localparam int LINE_ITEMS      = 1040;
   localparam int TALL_ITEMS      = 160;
   localparam int MAX_PRINTED     = 60;
   localparam longint RUN_LIMIT_NS = 2_000_000;

   // DUT ports, all inputs known from time zero
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   // shadow registers, raw as written
   logic [IMAGE_ROWS_W-1:0]  cfg_rows = IMAGE_ROWS_RESET;
   logic [IMAGE_COLS_W-1:0]  cfg_cols = IMAGE_COLS_RESET;
   logic [HALF_KERNEL_W-1:0] cfg_hr   = HALF_KERNEL_RESET;
   logic [HALF_KERNEL_W-1:0] cfg_hc   = HALF_KERNEL_RESET;

   // predictor state: pixel history per line slot, vertical sums per fast
   // index, recent vertical sums of the current line, horizontal accumulator
   logic [PIXEL_FIELD_W-1:0] pixel_history [SLOTS][MAX_ROWS];
   logic [COL_SUM_BITS-1:0]  vertical_sums [MAX_ROWS];
   logic [COL_SUM_BITS-1:0]  line_sums_recent [SLOTS];
   logic [WIN_SUM_BITS-1:0]  box_acc = '0;
   int unsigned              pos_row = 0;
   int unsigned              pos_col = 0;

   rsp_payload_type window_sums_due[$];
   int              mismatch_count = 0;

   // pacing controls shared by the stimulus and the stall process
   bit sender_calm   = 1'b0;
   bit receiver_calm = 1'b0;
   bit hold_request  = 1'b0;

   box_filter_window_sum_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin : clock_gen
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   // zero sizes act as one, large sizes saturate
   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // bias toward the extremes so that every pixel bit toggles both ways
   function automatic logic [PIXEL_FIELD_W-1:0] random_pixel();
      int pick = $urandom_range(0, 7);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return PIXEL_FIELD_W'($urandom);
   endfunction

   // ------------------------------------------------------------------------
   // predictor: one accepted pixel beat in, zero or one window sum queued
   // ------------------------------------------------------------------------
   task automatic predict_window_sum(input req_payload_type beat);
      int unsigned     rows, cols, hr, hc, r, c, colsum, acc;
      rsp_payload_type result;
      rows = clamp_size(cfg_rows, MAX_ROWS);
      cols = clamp_size(cfg_cols, MAX_COLS);
      hr   = (cfg_hr > MAX_HALF_KERNEL) ? MAX_HALF_KERNEL : cfg_hr;
      hc   = (cfg_hc > MAX_HALF_KERNEL) ? MAX_HALF_KERNEL : cfg_hc;

      if (beat.frame_start) begin
         pos_row = 0;
         pos_col = 0;
      end
      r = pos_row % MAX_ROWS;
      c = pos_col % MAX_COLS;

      // vertical running sum over the last 2*hc+1 lines at this fast index
      if (c == 0) begin
         colsum = beat.pixel;
      end else begin
         colsum = vertical_sums[r] + beat.pixel;
         if (c >= 2 * hc + 1)
            colsum -= pixel_history[(c - 2 * hc - 1) % SLOTS][r];
      end
      vertical_sums[r] = COL_SUM_BITS'(colsum);
      pixel_history[c % SLOTS][r] = beat.pixel;

      // horizontal running sum over the last 2*hr+1 vertical sums
      if (r == 0) begin
         acc = vertical_sums[r];
      end else begin
         acc = box_acc + vertical_sums[r];
         if (r >= 2 * hr + 1)
            acc -= line_sums_recent[(r - 2 * hr - 1) % SLOTS];
      end
      box_acc = WIN_SUM_BITS'(acc);
      line_sums_recent[r % SLOTS] = vertical_sums[r];

      if (r >= 2 * hr && c >= 2 * hc && r < rows && c < cols) begin
         result.window_sum = box_acc;
         result.centre_row = CENTRE_ROW_W'(r - hr);
         result.centre_col = CENTRE_COL_W'(c - hc);
         result.frame_done = (r + 1 == rows) && (c + 1 == cols);
         window_sums_due.push_back(result);
      end

      if (r + 1 >= rows) begin
         pos_row = 0;
         pos_col = (c + 1 >= cols) ? 0 : c + 1;
      end else begin
         pos_row = r + 1;
         pos_col = c;
      end
   endtask

   // ------------------------------------------------------------------------
   // pixel beat driver: called at a falling edge, returns at a falling edge
   // with valid possibly still high so back-to-back beats need no gap
   // ------------------------------------------------------------------------
   task automatic send_pixel(input logic [PIXEL_FIELD_W-1:0] pixel_value,
                             input logic start_flag);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= '{pixel: pixel_value, frame_start: start_flag};
      do @(posedge clock); while (req_stall);
      predict_window_sum(req_payload);
      @(negedge clock);
      gap = sender_calm ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // pause the sender until every predicted beat has come out, then let the
   // pipeline settle; a missing result is flagged here and forgotten
   task automatic wait_until_drained();
      int waited = 0;
      while (window_sums_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (window_sums_due.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived",
                                   window_sums_due.size()));
         window_sums_due.delete();
      end
      repeat (PIPE_SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type which,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (which)
         CSR_IMAGE_ROWS:       cfg_rows = value[IMAGE_ROWS_W-1:0];
         CSR_IMAGE_COLS:       cfg_cols = value[IMAGE_COLS_W-1:0];
         CSR_HALF_KERNEL_ROWS: cfg_hr   = value[HALF_KERNEL_W-1:0];
         CSR_HALF_KERNEL_COLS: cfg_hc   = value[HALF_KERNEL_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // registers change only with the block idle; the next beat always carries
   // frame_start so no stale store entry is ever read
   task automatic configure(input int unsigned rows_value, input int unsigned cols_value,
                            input int unsigned hr_value, input int unsigned hc_value);
      wait_until_drained();
      write_register(CSR_IMAGE_ROWS,       CSR_DATA_W'(rows_value));
      write_register(CSR_IMAGE_COLS,       CSR_DATA_W'(cols_value));
      write_register(CSR_HALF_KERNEL_ROWS, CSR_DATA_W'(hr_value));
      write_register(CSR_HALF_KERNEL_COLS, CSR_DATA_W'(hc_value));
      csr_valid <= 1'b0;
   endtask

   // a run of random pixels: frame_start on the first, rare stray restarts
   task automatic send_frames(input int count, input int hold_at, input int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == hold_at)
            hold_request = 1'b1;
         if (i == pause_at) begin
            req_valid <= 1'b0;
            wait_until_drained();
         end
         send_pixel(random_pixel(), (i == 0) || ($urandom_range(0, 127) == 0));
      end
      req_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // 3x3 frame, 3x3 window: an aborted start, then a restart via frame_start;
   // exactly one sum with frame_done, pixels at both extremes
   task automatic test_three_by_three_window();
      configure(3, 3, 1, 1);
      send_pixel(16'hFFFF, 1'b1);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b1);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h1234, 1'b0);
      send_pixel(16'h8000, 1'b0);
      send_pixel(16'h7FFF, 1'b0);
      send_pixel(16'h0001, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h00FF, 1'b0);
      send_pixel(16'hFF00, 1'b0);
      req_valid <= 1'b0;
   endtask

   // window wider than the line: nothing may come out
   task automatic test_oversized_window();
      configure(2, 3, 1, 1);
      send_pixel(16'hFFFF, 1'b1);
      for (int i = 0; i < 5; i++)
         send_pixel(random_pixel(), 1'b0);
      req_valid <= 1'b0;
   endtask

   // zero sizes act as 1x1 with a 1x1 window: every beat wraps position
   // without frame_start and closes its own frame
   task automatic test_single_pixel_image();
      configure(0, 0, 0, 0);
      send_pixel(16'hABCD, 1'b1);
      send_pixel(16'h5432, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b0);
      req_valid <= 1'b0;
   endtask

   // rows saturate to a full 1024-pixel line, one line per frame; the
   // receiver holds off for a long stretch so the block backs up its input
   task automatic test_full_line_with_hold_off();
      sender_calm   = 1'b1;
      receiver_calm = 1'b0;
      configure(2047, 1, $urandom_range(0, MAX_HALF_KERNEL), 0);
      send_frames(LINE_ITEMS, 150, -1);
      sender_calm = 1'b0;
   endtask

   // lines saturate at the column limit; the sender stops mid-frame until
   // every result is out, then carries on in the same frame
   task automatic test_tall_frame_with_pause();
      configure(2, 8191, 0, $urandom_range(0, MAX_HALF_KERNEL));
      send_frames(TALL_ITEMS, -1, TALL_ITEMS / 2);
   endtask

   // random small frames and windows, mostly windows that fit
   task automatic test_random_frames(input int item_budget);
      int sent = 0;
      int rows, cols, hr, hc, count;
      while (sent < item_budget) begin
         rows = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
         cols = $urandom_range(1, 12);
         hr   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_HALF_KERNEL)
                                            : $urandom_range(0, (rows - 1) / 2);
         hc   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_HALF_KERNEL)
                                            : $urandom_range(0, (cols - 1) / 2);
         sender_calm   = ($urandom_range(0, 3) == 0);
         receiver_calm = ($urandom_range(0, 3) == 0);
         configure(rows, cols, hr, hc);
         count = rows * cols * $urandom_range(1, 3) + $urandom_range(0, rows);
         if (count > 240)
            count = 240;
         if (count > item_budget - sent)
            count = item_budget - sent;
         send_frames(count, -1, -1);
         sent += count;
      end
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // receiver: random stalls, plus a counted hold-off on request
   // ------------------------------------------------------------------------
   initial begin : rsp_backpressure
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            if (hold_request) begin
               hold_request = 1'b0;
               stall_left   = HOLD_OFF_CYCLES;
            end else if (!receiver_calm && $urandom_range(0, 2) == 0) begin
               stall_left = idle_length();
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // checker: every accepted result beat against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      rsp_payload_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (window_sums_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result sum=%0d row=%0d col=%0d",
                                      rsp_payload.window_sum, rsp_payload.centre_row,
                                      rsp_payload.centre_col));
         end else begin
            due = window_sums_due.pop_front();
            if (rsp_payload.window_sum !== due.window_sum)
               report_mismatch($sformatf("window_sum %0d, expected %0d",
                                         rsp_payload.window_sum, due.window_sum));
            if (rsp_payload.centre_row !== due.centre_row)
               report_mismatch($sformatf("centre_row %0d, expected %0d",
                                         rsp_payload.centre_row, due.centre_row));
            if (rsp_payload.centre_col !== due.centre_col)
               report_mismatch($sformatf("centre_col %0d, expected %0d",
                                         rsp_payload.centre_col, due.centre_col));
            if (rsp_payload.frame_done !== due.frame_done)
               report_mismatch($sformatf("frame_done %0b, expected %0b",
                                         rsp_payload.frame_done, due.frame_done));
         end
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_three_by_three_window();
      test_oversized_window();
      test_single_pixel_image();
      test_full_line_with_hold_off();
      test_tall_frame_with_pause();
      test_random_frames(RANDOM_ITEMS - LINE_ITEMS - TALL_ITEMS);

      // let the tail drain and the pipeline settle so that stray beats show up
      wait_until_drained();
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
